### sv/lasq_pkg.sv
// ----------------------------------------------------------------------------
// lasq_pkg
// shared constants, controller states and control/status bundles for the
// longest arithmetic subsequence core
// ----------------------------------------------------------------------------
package lasq_pkg;

  localparam int DEF_MAX_ITEMS  = 64;
  localparam int DEF_VALUE_BITS = 16;
  localparam int IN_VALUE_W     = 16;
  localparam int IN_DATA_W      = 16;
  localparam int BEST_W         = 7;
  localparam int OUT_DATA_W     = 8;
  localparam int START_LEN      = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD_J,
    ST_LD_J,
    ST_SEARCH,
    ST_LD_P,
    ST_WR_P,
    ST_INC,
    ST_FIN
  } lasq_state_t;

  typedef struct packed {
    logic capture;
    logic store;
    logic set_ovf;
    logic rd_j;
    logic ld_j;
    logic k_step;
    logic p_rd;
    logic no_match;
    logic wr_p;
    logic inc;
    logic fin_load;
  } lasq_cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic j_zero;
    logic j_last;
    logic k_zero;
    logic match;
    logic last;
    logic out_free;
  } lasq_sts_t;

endpackage

### sv/longest_arithmetic_subsequence_core.sv
// ----------------------------------------------------------------------------
// longest_arithmetic_subsequence_core
// streams in unsigned values and reports the longest arithmetic subsequence
// of each run when the item marked last arrives
// ----------------------------------------------------------------------------
// Items are taken one at a time. How long item number i of a run occupies
// the block is set by the backward predecessor search, which reads the value
// memory one entry per cycle. An item past MAX_ITEMS is dropped and raises
// the overflow flag. An item marked last also loads the result, and waits
// while an earlier result still waits. The result register lets the next run
// start while a result waits.
module longest_arithmetic_subsequence_core
  import lasq_pkg::*;
#(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // value[15:0]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // best_length[6:0], zero pad
  output logic                  out_tuser   // overflow
);

  lasq_cmd_t cmd;
  lasq_sts_t sts;

  lasq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lasq_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  // one item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while previous item still in work");

  // a new result never overwrites one still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // pair writes stay inside the current run
  a_pair_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_p |-> (!sts.full && !sts.count_zero))
    else $error("pair write outside stored items");

endmodule

### sv/lasq_ctrl.sv
// ----------------------------------------------------------------------------
// lasq_ctrl
// sequencer: walks every earlier element j for the new item, then searches
// backward for a predecessor k of each pair
// ----------------------------------------------------------------------------
module lasq_ctrl
  import lasq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lasq_sts_t sts,
  output lasq_cmd_t cmd
);

  lasq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.full) begin
          state_nxt = sts.last ? ST_FIN : ST_IDLE;
        end else if (sts.count_zero) begin
          state_nxt = ST_INC;
        end else begin
          state_nxt = ST_RD_J;
        end
      end
      ST_RD_J: state_nxt = ST_LD_J;
      ST_LD_J: begin
        state_nxt = sts.j_zero ? ST_WR_P : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.match) begin
          state_nxt = ST_LD_P;
        end else if (sts.k_zero) begin
          state_nxt = ST_WR_P;
        end
      end
      ST_LD_P: state_nxt = ST_WR_P;
      ST_WR_P: begin
        state_nxt = sts.j_last ? ST_INC : ST_RD_J;
      end
      ST_INC: begin
        state_nxt = sts.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_CHECK: begin
        cmd.set_ovf = sts.full;
        cmd.store   = !sts.full;
      end
      ST_RD_J: cmd.rd_j = 1'b1;
      ST_LD_J: cmd.ld_j = 1'b1;
      ST_SEARCH: begin
        if (sts.match) begin
          cmd.p_rd = 1'b1;
        end else if (sts.k_zero) begin
          cmd.no_match = 1'b1;
        end else begin
          cmd.k_step = 1'b1;
        end
      end
      ST_LD_P: ;
      ST_WR_P: cmd.wr_p = 1'b1;
      ST_INC:  cmd.inc  = 1'b1;
      ST_FIN:  cmd.fin_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

### sv/lasq_dp.sv
// ----------------------------------------------------------------------------
// lasq_dp
// datapath: value memory, pair length memory, counters, running best and
// the output register
// ----------------------------------------------------------------------------
module lasq_dp
  import lasq_pkg::*;
#(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  input  lasq_cmd_t             cmd,
  output lasq_sts_t             sts
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int LW = CW;
  localparam int PD = 1 << (2 * IW);
  localparam int TW = VALUE_BITS + 2;

  logic [VALUE_BITS-1:0] vmem [MAX_ITEMS];
  logic [LW-1:0]         pmem [PD];

  logic [VALUE_BITS-1:0] v_r;
  logic                  last_r;
  logic [CW-1:0]         count_r;
  logic [IW-1:0]         j_r;
  logic [IW-1:0]         k_r;
  logic [TW-1:0]         target_r;
  logic                  use_p_r;
  logic [LW-1:0]         best_r;
  logic                  ovf_r;
  logic [VALUE_BITS-1:0] vrd_r;
  logic [LW-1:0]         prd_r;
  logic                  out_valid_r;
  logic [BEST_W-1:0]     out_best_r;
  logic                  out_ovf_r;

  logic [IN_VALUE_W+VALUE_BITS-1:0] v_ext;
  logic [IW-1:0]                    vrd_addr;
  logic                             vrd_en;
  logic [IW-1:0]                    i_idx;
  logic [LW-1:0]                    len;
  logic [LW-1:0]                    result;
  logic [LW+BEST_W-1:0]             result_ext;
  logic [TW-1:0]                    target_nxt;

  assign v_ext      = {{VALUE_BITS{1'b0}}, in_tdata[IN_VALUE_W-1:0]};
  assign i_idx      = count_r[IW-1:0];
  assign len        = use_p_r ? (prd_r + LW'(1)) : LW'(START_LEN);
  assign result     = (count_r < CW'(2)) ? LW'(count_r) : best_r;
  assign result_ext = {{BEST_W{1'b0}}, result};
  assign target_nxt = {1'b0, vrd_r, 1'b0} - {2'b00, v_r};

  always_comb begin
    vrd_en   = cmd.rd_j | cmd.ld_j | cmd.k_step;
    vrd_addr = j_r;
    if (cmd.ld_j) begin
      vrd_addr = j_r - IW'(1);
    end else if (cmd.k_step) begin
      vrd_addr = k_r - IW'(1);
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (cmd.store) vmem[i_idx] <= v_r;
    if (vrd_en) vrd_r <= vmem[vrd_addr];
  end

  // pair length memory, row j column i
  always_ff @(posedge clk) begin
    if (cmd.wr_p) pmem[{j_r, i_idx}] <= len;
    if (cmd.p_rd) prd_r <= pmem[{k_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_r    <= v_ext[VALUE_BITS-1:0];
      last_r <= in_tlast;
    end
    if (cmd.ld_j) begin
      target_r <= target_nxt;
      k_r      <= j_r - IW'(1);
    end else if (cmd.k_step) begin
      k_r <= k_r - IW'(1);
    end
    if (cmd.ld_j || cmd.no_match) begin
      use_p_r <= 1'b0;
    end else if (cmd.p_rd) begin
      use_p_r <= 1'b1;
    end
    if (cmd.store) begin
      j_r <= '0;
    end else if (cmd.wr_p) begin
      j_r <= j_r + IW'(1);
    end
    if (cmd.fin_load) begin
      out_best_r <= result_ext[BEST_W-1:0];
      out_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin_load) begin
        count_r <= '0;
        best_r  <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (cmd.inc) count_r <= count_r + CW'(1);
        if (cmd.set_ovf) ovf_r <= 1'b1;
        if (cmd.wr_p && (len > best_r)) best_r <= len;
      end
      if (cmd.fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.full       = (count_r == CW'(MAX_ITEMS));
    sts.count_zero = (count_r == '0);
    sts.j_zero     = (j_r == '0);
    sts.j_last     = ((CW'(j_r) + CW'(1)) == count_r);
    sts.k_zero     = (k_r == '0);
    sts.match      = ({2'b00, vrd_r} == target_r);
    sts.last       = last_r;
    sts.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-BEST_W){1'b0}}, out_best_r};
  assign out_tuser  = out_ovf_r;

endmodule
